>>> hw/rtl/vcpl_pkg.sv
//------------------------------------------------------------------------------
// vcpl_pkg
// types and constants shared by the voxel to camera pixel lookup
//------------------------------------------------------------------------------
`default_nettype none
package vcpl_pkg;
   localparam int COEF_W = 32;
   localparam logic OP_MAP  = 1'b0;
   localparam logic OP_LOAD = 1'b1;
   localparam logic [1:0] CSR_CAMERA_COUNT = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef struct packed {
      logic               opcode;
      logic [7:0]         voxel_x;
      logic [7:0]         voxel_y;
      logic [7:0]         voxel_z;
      logic [6:0]         word_address;
      logic signed [31:0] word_value;
   } req_type;

   typedef struct packed {
      logic               voxel_valid;
      logic signed [3:0]  camera_index;
      logic [23:0]        pixel_index;
   } rsp_type;
endpackage
`default_nettype wire

>>> hw/rtl/vcpl_divider.sv
//------------------------------------------------------------------------------
// vcpl_divider
// unsigned restoring divider, one quotient bit per cycle
//------------------------------------------------------------------------------
`default_nettype none
module vcpl_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [63:0] divisor,
   output logic             done,
   output logic [63:0]      quotient
);
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[63]} - {1'b0, dvs_ff};
      if (start) begin
         rem_in = '0; quo_in = dividend; cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; cnt_ff <= cnt_in;
      if (start) dvs_ff <= divisor;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

>>> hw/rtl/voxel_to_camera_pixel_lut.sv
//------------------------------------------------------------------------------
// voxel_to_camera_pixel_lut
// maps a voxel index to the first camera that sees it and its pixel index
//------------------------------------------------------------------------------
// load beat: written to the table when accepted; map beat: accepted, then the world
// point is computed, then per camera a multiply-accumulate of the three rows; a camera
// with w > 0 adds two divisions on the one shared divider and a range check; a hit
// adds the pixel index step, then the output register; one beat at a time, input
// stalled while busy; reset clears control, table undefined
`default_nettype none
module voxel_to_camera_pixel_lut #(
   parameter int MAX_CAMERAS = 8,
   parameter int FRAC_BITS   = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire vcpl_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output vcpl_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [12:0]       csr_data
);
   localparam int DEPTH = MAX_CAMERAS * 12 + 6;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(MAX_CAMERAS + 1);
   localparam logic [AW-1:0] SIZE_ADDR = AW'(MAX_CAMERAS * 12);

   typedef enum logic [3:0] {
      S_IDLE, S_PT_RD, S_PT_MUL, S_PT_SAT, S_CAM, S_MAC_RD, S_MAC_MUL,
      S_MAC_ADD, S_CHK, S_DIV, S_DIV_WAIT, S_HIT, S_OUT
   } state_type;

   logic [31:0] mem [DEPTH];
   logic [AW-1:0] raddr;
   logic signed [31:0] rdata_ff;

   state_type state_ff;
   logic [3:0]  cam_cnt_ff;
   logic [12:0] width_ff, height_ff;
   vcpl_pkg::req_type req_ff;
   logic signed [31:0] pt_ff [3];
   logic [1:0] axis_ff, col_ff, row_ff;
   logic [CW-1:0] cam_ff;
   logic signed [63:0] acc_ff [3];
   logic signed [63:0] prod_ff;
   logic div_sel_ff, div_start_ff;
   logic signed [33:0] q_ff [2];
   vcpl_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic [CW-1:0] cams;
   logic signed [63:0] div_a, mag;
   logic [63:0] quo;
   logic div_done;
   logic signed [63:0] pt_sum;
   logic signed [63:0] qs;

   assign cams = (cam_cnt_ff > 4'(MAX_CAMERAS)) ? CW'(MAX_CAMERAS) : CW'(cam_cnt_ff);
   assign div_a = div_sel_ff ? acc_ff[1] : acc_ff[0];
   assign mag = div_a[63] ? -div_a : div_a;

   vcpl_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_ff),
      .dividend({mag[62:0], 1'b0} + acc_ff[2]),
      .divisor({acc_ff[2][62:0], 1'b0}),
      .done(div_done), .quotient(quo)
   );

   always_comb begin
      raddr = '0;
      case (state_ff)
         S_PT_RD: raddr = AW'(SIZE_ADDR + AW'(axis_ff) + (col_ff[0] ? AW'(3) : AW'(0)));
         S_PT_MUL: raddr = AW'(SIZE_ADDR + AW'(axis_ff) + (col_ff[0] ? AW'(3) : AW'(0)));
         S_MAC_RD: raddr = AW'(cam_ff * 12 + row_ff * 4 + col_ff);
         default: raddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (!reset && state_ff == S_IDLE && req_valid && req_data.opcode == vcpl_pkg::OP_LOAD
          && req_data.word_address < 7'(DEPTH))
         mem[req_data.word_address[AW-1:0]] <= req_data.word_value;
      rdata_ff <= mem[raddr];
   end

   assign pt_sum = prod_ff + 64'(rdata_ff);
   assign qs = div_a[63] ? -$signed(quo) : $signed(quo);

   always_ff @(posedge clock) begin
      div_start_ff <= 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_ff <= req_data;
               axis_ff <= '0; col_ff <= '0;
               state_ff <= (req_data.opcode == vcpl_pkg::OP_LOAD) ? S_IDLE : S_PT_RD;
            end
         end
         S_PT_RD: state_ff <= S_PT_MUL;
         S_PT_MUL: begin
            // size read, now fetch base
            if (!col_ff[0]) begin
               prod_ff <= $signed({1'b0, (axis_ff == 2'd0) ? req_ff.voxel_x :
                          (axis_ff == 2'd1) ? req_ff.voxel_y : req_ff.voxel_z}) * rdata_ff;
               col_ff <= 2'd1;
               state_ff <= S_PT_RD;
            end else state_ff <= S_PT_SAT;
         end
         S_PT_SAT: begin
            pt_ff[axis_ff] <= (pt_sum > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                              (pt_sum < -64'sh80000000) ? 32'sh80000000 : pt_sum[31:0];
            col_ff <= '0;
            axis_ff <= axis_ff + 2'd1;
            if (axis_ff == 2'd2) begin
               cam_ff <= '0; state_ff <= S_CAM;
            end else state_ff <= S_PT_RD;
         end
         S_CAM: begin
            if (cam_ff >= cams) begin
               rsp_ff <= '{voxel_valid: 1'b0, camera_index: -4'sd1, pixel_index: '0};
               state_ff <= S_OUT;
            end else begin
               row_ff <= '0; col_ff <= '0; state_ff <= S_MAC_RD;
            end
         end
         S_MAC_RD: state_ff <= S_MAC_MUL;
         S_MAC_MUL: begin
            prod_ff <= (col_ff == 2'd3) ? 64'(rdata_ff) : rdata_ff * pt_ff[col_ff];
            state_ff <= S_MAC_ADD;
         end
         S_MAC_ADD: begin
            acc_ff[row_ff] <= ((col_ff == 2'd0) ? 64'sd0 : acc_ff[row_ff]) +
               ((col_ff == 2'd3) ? prod_ff : (prod_ff >>> FRAC_BITS));
            col_ff <= col_ff + 2'd1;
            state_ff <= S_MAC_RD;
            if (col_ff == 2'd3) begin
               row_ff <= row_ff + 2'd1;
               if (row_ff == 2'd2) state_ff <= S_CHK;
            end
         end
         S_CHK: begin
            if (acc_ff[2] <= 0) begin
               cam_ff <= cam_ff + 1'b1; state_ff <= S_CAM;
            end else begin
               div_sel_ff <= 1'b0; div_start_ff <= 1'b1; state_ff <= S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               q_ff[div_sel_ff] <= (qs > 64'sh7FFFFFFF) ? 34'sh7FFFFFFF :
                                   (qs < -64'sh80000000) ? -34'sh80000000 : qs[33:0];
               if (!div_sel_ff) begin
                  div_sel_ff <= 1'b1; div_start_ff <= 1'b1;
               end else state_ff <= S_DIV;
            end
         end
         S_DIV: begin
            if (!q_ff[0][33] && !q_ff[1][33] && q_ff[0] < 34'(width_ff)
                && q_ff[1] < 34'(height_ff)) begin
               prod_ff <= 64'({13'd0, q_ff[1][12:0]} * {13'd0, width_ff});
               state_ff <= S_HIT;
            end else begin
               cam_ff <= cam_ff + 1'b1; state_ff <= S_CAM;
            end
         end
         S_HIT: begin
            rsp_ff <= '{voxel_valid: 1'b1, camera_index: 4'(cam_ff),
                        pixel_index: 24'(prod_ff[25:0] + 26'(q_ff[0][12:0]))};
            state_ff <= S_OUT;
         end
         S_OUT: if (!rsp_valid_ff || !rsp_stall) state_ff <= S_IDLE;
         default: state_ff <= S_IDLE;
      endcase
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) rsp_data <= rsp_ff;
      if (csr_write) begin
         case (csr_index)
            vcpl_pkg::CSR_CAMERA_COUNT: cam_cnt_ff <= csr_data[3:0];
            vcpl_pkg::CSR_IMAGE_WIDTH:  width_ff <= csr_data;
            vcpl_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_data;
            default: ;
         endcase
      end
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; div_start_ff <= 1'b0;
         cam_cnt_ff <= 4'd1; width_ff <= 13'd640; height_ff <= 13'd480;
      end
   end

   assign req_stall = reset || (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

>>> dv/testbench.sv
//------------------------------------------------------------------------------
// testbench
// self-checking test of the voxel to camera pixel lookup: loads projection
// scenes into the coefficient table, maps directed and random voxels under
// several register settings and idle/stall mixes, and compares every result
// beat with an in-bench projection predictor
//------------------------------------------------------------------------------
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC        = 16;
   localparam int MAX_CAM     = 8;
   localparam int TABLE_DEPTH = MAX_CAM * 12 + 6;
   localparam int SIZE_ADDR   = MAX_CAM * 12;
   localparam int BASE_ADDR   = MAX_CAM * 12 + 3;
   localparam int IDLE_LIMIT  = 20000;
   localparam int SETTLE      = 200;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   vcpl_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   vcpl_pkg::rsp_type rsp_data;
   logic              csr_write = 1'b0;
   logic [1:0]        csr_index = '0;
   logic [12:0]       csr_data = '0;

   int                coef_table [TABLE_DEPTH];
   int unsigned       camera_count;
   int unsigned       image_width;
   int unsigned       image_height;
   vcpl_pkg::rsp_type pending_pixels [$];
   int                error_count = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;
   int                hold_left = 0;
   int                quiet_cycles = 0;

   voxel_to_camera_pixel_lut dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint div_round(longint a, longint b);
      longint unsigned mag;
      longint unsigned q;
      longint unsigned bu;
      bu = b;
      mag = (a < 0) ? longint'(-a) : a;
      q = (2 * mag + bu) / (2 * bu);
      return clamp32((a < 0) ? -longint'(q) : longint'(q));
   endfunction

   function automatic vcpl_pkg::rsp_type project_voxel(vcpl_pkg::req_type r);
      longint  pt [3];
      longint  acc [3];
      longint  idx [3];
      longint  col;
      longint  row;
      longint  pix;
      int      cams;
      vcpl_pkg::rsp_type res;
      res.voxel_valid  = 1'b0;
      res.camera_index = -4'sd1;
      res.pixel_index  = '0;
      idx[0] = longint'(r.voxel_x);
      idx[1] = longint'(r.voxel_y);
      idx[2] = longint'(r.voxel_z);
      for (int a = 0; a < 3; a++)
         pt[a] = clamp32(idx[a] * longint'(coef_table[SIZE_ADDR + a])
                         + longint'(coef_table[BASE_ADDR + a]));
      cams = (camera_count > MAX_CAM) ? MAX_CAM : camera_count;
      for (int c = 0; c < cams; c++) begin
         for (int rr = 0; rr < 3; rr++) begin
            acc[rr] = longint'(coef_table[c * 12 + rr * 4 + 3]);
            for (int j = 0; j < 3; j++)
               acc[rr] += (longint'(coef_table[c * 12 + rr * 4 + j]) * pt[j]) >>> FRAC;
         end
         if (acc[2] <= 0) continue;
         col = div_round(acc[0], acc[2]);
         row = div_round(acc[1], acc[2]);
         if (col >= 0 && row >= 0 && col < longint'(image_width)
             && row < longint'(image_height)) begin
            pix = row * longint'(image_width) + col;
            res.voxel_valid  = 1'b1;
            res.camera_index = 4'(c);
            res.pixel_index  = pix[23:0];
            return res;
         end
      end
      return res;
   endfunction

   task automatic send_beat(vcpl_pkg::req_type r);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      if (r.opcode == vcpl_pkg::OP_LOAD) begin
         if (r.word_address < TABLE_DEPTH) coef_table[r.word_address] = r.word_value;
      end else begin
         pending_pixels.push_back(project_voxel(r));
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [12:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         vcpl_pkg::CSR_CAMERA_COUNT: camera_count = value[3:0];
         vcpl_pkg::CSR_IMAGE_WIDTH:  image_width  = value;
         vcpl_pkg::CSR_IMAGE_HEIGHT: image_height = value;
         default: ;
      endcase
   endtask

   task automatic set_view(int cams, int w, int h);
      drain();
      write_reg(vcpl_pkg::CSR_CAMERA_COUNT, 13'(cams));
      write_reg(vcpl_pkg::CSR_IMAGE_WIDTH, 13'(w));
      write_reg(vcpl_pkg::CSR_IMAGE_HEIGHT, 13'(h));
   endtask

   function automatic vcpl_pkg::req_type load_beat(int addr, int value);
      vcpl_pkg::req_type r;
      r = vcpl_pkg::req_type'({$urandom, $urandom});
      r.opcode       = vcpl_pkg::OP_LOAD;
      r.word_address = 7'(addr);
      r.word_value   = value;
      return r;
   endfunction

   function automatic vcpl_pkg::req_type map_beat(int x, int y, int z);
      vcpl_pkg::req_type r;
      r = vcpl_pkg::req_type'({$urandom, $urandom});
      r.opcode  = vcpl_pkg::OP_MAP;
      r.voxel_x = 8'(x);
      r.voxel_y = 8'(y);
      r.voxel_z = 8'(z);
      return r;
   endfunction

   // plausible pinhole-like camera words: u = fx*x + cx, v = fy*y + cy, w = +-z + 1
   function automatic int scene_word(int addr);
      int rr;
      int cc;
      if ($urandom_range(9) == 0) return int'($urandom);
      if (addr >= BASE_ADDR) return (addr == BASE_ADDR + 2) ? 0 : -(128 << FRAC);
      if (addr >= SIZE_ADDR) return 1 << FRAC;
      rr = (addr % 12) / 4;
      cc = addr % 4;
      if (rr == 2) begin
         if (cc == 2) return ($urandom_range(5) == 0) ? -(1 << FRAC) : (1 << FRAC);
         return (cc == 3) ? (1 << FRAC) : 0;
      end
      if (cc == 3) return int'($urandom_range(0, 640)) << FRAC;
      if (cc == rr) return int'($urandom_range(1, 8)) << FRAC;
      return 0;
   endfunction

   task automatic load_scene();
      for (int a = 0; a < TABLE_DEPTH; a++) send_beat(load_beat(a, scene_word(a)));
   endtask

   task automatic test_directed();
      load_scene();
      send_beat(load_beat(TABLE_DEPTH, int'($urandom)));
      send_beat(load_beat(127, int'($urandom)));
      send_beat(map_beat(0, 0, 0));
      send_beat(map_beat(255, 255, 255));
      send_beat(map_beat(128, 128, 0));
      set_view(0, 640, 480);
      send_beat(map_beat(128, 128, 0));
      set_view(15, 640, 480);
      send_beat(map_beat(255, 0, 255));
      send_beat(map_beat(130, 130, 3));
      set_view(8, 0, 480);
      send_beat(map_beat(128, 128, 0));
      set_view(8, 640, 0);
      send_beat(map_beat(128, 128, 0));
      // far row with a wide image wraps the pixel index
      send_beat(load_beat(0, 1 << FRAC));
      send_beat(load_beat(5, 0));
      send_beat(load_beat(7, 4000 << FRAC));
      send_beat(load_beat(10, 1 << FRAC));
      send_beat(load_beat(11, 1 << FRAC));
      set_view(1, 8191, 8191);
      send_beat(map_beat(200, 128, 0));
      send_beat(load_beat(0, 32'sh7fffffff));
      send_beat(load_beat(3, 32'sh80000000));
      send_beat(load_beat(SIZE_ADDR, 32'sh7fffffff));
      send_beat(map_beat(255, 0, 0));
      send_beat(map_beat(0, 255, 255));
      set_view(1, 1, 1);
      send_beat(map_beat(128, 128, 0));
      load_scene();
   endtask

   task automatic test_random_phase(int idle, int stall, int items);
      int cams;
      int w;
      int h;
      case ($urandom_range(5))
         0: cams = 8;
         1: cams = $urandom_range(9, 15);
         default: cams = $urandom_range(1, 3);
      endcase
      w = ($urandom_range(3) == 0) ? (($urandom_range(1) == 0) ? 4096 : 8191)
                                   : $urandom_range(200, 2000);
      h = ($urandom_range(3) == 0) ? 4096 : $urandom_range(150, 2000);
      set_view(cams, w, h);
      send_idle_pct = idle;
      stall_pct = stall;
      for (int i = 0; i < items; i++) begin
         if ($urandom_range(99) < 12) begin
            if ($urandom_range(3) == 0)
               send_beat(load_beat($urandom_range(0, 127), int'($urandom)));
            else begin
               int a;
               a = $urandom_range(0, TABLE_DEPTH - 1);
               send_beat(load_beat(a, scene_word(a)));
            end
         end else begin
            send_beat(map_beat($urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255)));
         end
      end
      drain();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   task automatic test_backpressure();
      set_view(2, 640, 480);
      hold_left = 400;
      for (int i = 0; i < 20; i++)
         send_beat(map_beat($urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255)));
      drain();
      for (int i = 0; i < 10; i++)
         send_beat(map_beat($urandom_range(100, 160), $urandom_range(100, 160),
                            $urandom_range(0, 20)));
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      vcpl_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $error("result beat with no expectation: %h", rsp_data);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.voxel_valid !== want.voxel_valid) begin
               $error("voxel_valid expected %0d actual %0d", want.voxel_valid,
                      rsp_data.voxel_valid);
               error_count++;
            end
            if (rsp_data.camera_index !== want.camera_index) begin
               $error("camera_index expected %0d actual %0d", want.camera_index,
                      rsp_data.camera_index);
               error_count++;
            end
            if (rsp_data.pixel_index !== want.pixel_index) begin
               $error("pixel_index expected %0d actual %0d", want.pixel_index,
                      rsp_data.pixel_index);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int a = 0; a < TABLE_DEPTH; a++) coef_table[a] = 0;
      camera_count = 1;
      image_width  = 640;
      image_height = 480;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_phase(0, 0, 200);
      test_random_phase(46, 0, 200);
      test_random_phase(0, 46, 200);
      test_random_phase(14, 14, 200);
      test_backpressure();
      drain();
      repeat (SETTLE) @(negedge clock);
      if (error_count == 0 && pending_pixels.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/vcpl_pkg.sv
hw/rtl/vcpl_divider.sv
hw/rtl/voxel_to_camera_pixel_lut.sv
dv/testbench.sv
